[rtl/core/lox_pkg.sv]
// ----------------------------------------------------------------------------
// lox_pkg: shared types and constants of the lox token scanner
// Token kinds, scan modes, error codes and the request/response payloads.
// ----------------------------------------------------------------------------
package lox_pkg;

   localparam int PositionBitsDefault = 16;
   localparam int LineBitsDefault     = 16;
   localparam int PrefixDepth         = 6;

   typedef enum logic [5:0] {
      K_LPAREN = 6'd0, K_RPAREN = 6'd1, K_LBRACE = 6'd2, K_RBRACE = 6'd3,
      K_COMMA = 6'd4, K_DOT = 6'd5, K_MINUS = 6'd6, K_PLUS = 6'd7,
      K_SEMI = 6'd8, K_SLASH = 6'd9, K_STAR = 6'd10, K_BANG = 6'd11,
      K_BANG_EQ = 6'd12, K_EQ = 6'd13, K_EQ_EQ = 6'd14, K_GT = 6'd15,
      K_GT_EQ = 6'd16, K_LT = 6'd17, K_LT_EQ = 6'd18, K_IDENT = 6'd19,
      K_STRING = 6'd20, K_NUMBER = 6'd21, K_AND = 6'd22, K_CLASS = 6'd23,
      K_ELSE = 6'd24, K_FALSE = 6'd25, K_FOR = 6'd26, K_FUN = 6'd27,
      K_IF = 6'd28, K_NIL = 6'd29, K_OR = 6'd30, K_PRINT = 6'd31,
      K_RETURN = 6'd32, K_SUPER = 6'd33, K_THIS = 6'd34, K_TRUE = 6'd35,
      K_VAR = 6'd36, K_WHILE = 6'd37, K_ERROR = 6'd38, K_EOF = 6'd39
   } kind_type;

   typedef enum logic [3:0] {
      M_IDLE, M_SLASH, M_COMMENT, M_OP, M_IDENT, M_NUMBER, M_NUMDOT,
      M_FRACTION, M_STRING
   } mode_type;

   typedef enum logic [1:0] {
      E_NONE = 2'd0, E_UNTERMINATED = 2'd1, E_UNEXPECTED = 2'd2
   } err_type;

   typedef struct packed {
      logic [7:0] source_byte;
   } req_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] start_offset;
      logic [15:0] token_length;
      logic [15:0] line_number;
      logic [1:0]  error_kind;
      logic        last_of_run;
   } rsp_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

endpackage

[rtl/core/lox_req_if.sv]
// ----------------------------------------------------------------------------
// lox_req_if / lox_rsp_if: valid-ready channels of the scanner
// One interface per direction, with source and sink modports.
// ----------------------------------------------------------------------------
interface lox_req_if import lox_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lox_rsp_if import lox_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/lox_keyword.sv]
// ----------------------------------------------------------------------------
// lox_keyword: keyword classifier
// Maps a stored identifier prefix and its length to a keyword or identifier.
// ----------------------------------------------------------------------------
module lox_keyword import lox_pkg::*; (
   input  logic [PrefixDepth-1:0][7:0] prefix,
   input  logic [2:0]                  word_len,
   input  logic                        too_long,
   output kind_type                    kind
);

   logic [47:0] w;

   // pack letters so that compares are against string constants
   always_comb begin
      w = {prefix[0], prefix[1], prefix[2], prefix[3], prefix[4], prefix[5]};
   end

   always_comb begin
      kind = K_IDENT;
      if (!too_long) begin
         case (word_len)
            3'd2: begin
               if (w[47:32] == "if") kind = K_IF;
               else if (w[47:32] == "or") kind = K_OR;
            end
            3'd3: begin
               if (w[47:24] == "and") kind = K_AND;
               else if (w[47:24] == "for") kind = K_FOR;
               else if (w[47:24] == "fun") kind = K_FUN;
               else if (w[47:24] == "nil") kind = K_NIL;
               else if (w[47:24] == "var") kind = K_VAR;
            end
            3'd4: begin
               if (w[47:16] == "else") kind = K_ELSE;
               else if (w[47:16] == "this") kind = K_THIS;
               else if (w[47:16] == "true") kind = K_TRUE;
            end
            3'd5: begin
               if (w[47:40] == "c" && w[39:8] == "lass") kind = K_CLASS;
               else if (w[47:8] == "false") kind = K_FALSE;
               else if (w[47:8] == "print") kind = K_PRINT;
               else if (w[47:8] == "super") kind = K_SUPER;
               else if (w[47:40] == "w" && w[39:8] == "hile") kind = K_WHILE;
            end
            3'd6: begin
               if (w[47:40] == "r" && w[39:0] == "eturn") kind = K_RETURN;
            end
            default: kind = K_IDENT;
         endcase
      end
   end

endmodule

[rtl/core/lox_token_scanner_core.sv]
// ----------------------------------------------------------------------------
// lox_token_scanner_core: streaming Lox lexer
// Takes one source byte per request and returns zero to three tokens.
// ----------------------------------------------------------------------------
// path: a request passes the input register, then the token queue, to its first token
// throughput: one request per cycle while each yields at most one token and rsp is ready;
//   a request with more tokens holds the input while the 3-entry queue drains
// reset: synchronous; mode idle, offset 0, line 1, queue empty
module lox_token_scanner_core import lox_pkg::*; #(
   parameter int POSITION_BITS = PositionBitsDefault,
   parameter int LINE_BITS     = LineBitsDefault
) (
   input logic    clock,
   input logic    reset,
   lox_req_if.sink   req,
   lox_rsp_if.source rsp
);

   localparam logic [POSITION_BITS-1:0] PosMax = '1;
   localparam logic [LINE_BITS-1:0]     LineMax = '1;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // scanner state
   mode_type                   mode_ff, mode_in;
   logic [7:0]                 pend_ff, pend_in;
   logic [POSITION_BITS-1:0]   start_ff, start_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic [LINE_BITS-1:0]       line_ff, line_in;
   logic [PrefixDepth-1:0][7:0] prefix_ff;
   logic                       toolong_ff, toolong_in;

   // output token queue: up to three tokens from one byte
   rsp_type    q_ff [3];
   logic [1:0] q_cnt_ff;
   logic [1:0] q_head_ff;

   rsp_type    tok [3];
   logic [1:0] tok_cnt;
   logic       pw_en;
   logic [2:0] pw_idx;

   logic       fire;
   logic [7:0] c;
   logic [POSITION_BITS-1:0] p, len_ps, len_ps1;
   kind_type   kw_kind;

   assign c    = in_byte_ff;
   assign p    = pos_ff;
   // scan when the queue is empty or its last token leaves this cycle
   assign fire = in_valid_ff && (q_cnt_ff == 2'd0 || (q_cnt_ff == 2'd1 && rsp.ready));

   assign len_ps  = (p > start_ff) ? p - start_ff : '0;
   assign len_ps1 = (len_ps != '0) ? len_ps - 1'b1 : '0;

   lox_keyword u_kw (
      .prefix   (prefix_ff),
      .word_len ((len_ps > POSITION_BITS'(6)) ? 3'd7 : len_ps[2:0]),
      .too_long (toolong_ff),
      .kind     (kw_kind)
   );

   function automatic logic [15:0] sat16p(input logic [POSITION_BITS-1:0] v);
      if (POSITION_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
      return 16'(v);
   endfunction

   function automatic logic [15:0] sat16l(input logic [LINE_BITS-1:0] v);
      if (LINE_BITS > 16 && (v >> 16) != '0) return 16'hFFFF;
      return 16'(v);
   endfunction

   function automatic kind_type op_kind(input logic [7:0] ch, input logic pair);
      kind_type b;
      case (ch)
         "!": b = K_BANG;
         "=": b = K_EQ;
         ">": b = K_GT;
         default: b = K_LT;
      endcase
      return pair ? kind_type'(b + 6'd1) : b;
   endfunction

   // one pass of the scanner over the registered byte
   always_comb begin
      logic absorbed;
      logic [LINE_BITS-1:0] ln;
      rsp_type t;
      absorbed   = 1'b0;
      ln         = line_ff;
      mode_in    = mode_ff;
      pend_in    = pend_ff;
      start_in   = start_ff;
      pos_in     = pos_ff;
      toolong_in = toolong_ff;
      pw_en      = 1'b0;
      pw_idx     = 3'd0;
      tok_cnt    = 2'd0;
      t          = '0;
      for (int i = 0; i < 3; i++) tok[i] = '0;

      // resolve the token that waits on this byte
      case (mode_ff)
         M_SLASH: begin
            if (c == "/") begin
               mode_in = M_COMMENT; absorbed = 1'b1;
            end else begin
               t.token_kind = K_SLASH; t.start_offset = sat16p(start_ff);
               t.token_length = 16'd1; tok[tok_cnt] = t; tok_cnt++;
            end
         end
         M_COMMENT: if (c != "\n" && c != 8'd0) absorbed = 1'b1;
         M_OP: begin
            t.start_offset = sat16p(start_ff);
            if (c == "=") begin
               t.token_kind = op_kind(pend_ff, 1'b1); t.token_length = 16'd2;
               mode_in = M_IDLE; absorbed = 1'b1;
            end else begin
               t.token_kind = op_kind(pend_ff, 1'b0); t.token_length = 16'd1;
            end
            tok[tok_cnt] = t; tok_cnt++;
         end
         M_IDENT: begin
            if (is_alpha(c) || is_digit(c)) begin
               absorbed = 1'b1;
               if (len_ps >= POSITION_BITS'(6) || p >= PosMax) toolong_in = 1'b1;
               else begin
                  pw_en = 1'b1; pw_idx = len_ps[2:0];
               end
            end else begin
               t.token_kind = kw_kind; t.start_offset = sat16p(start_ff);
               t.token_length = sat16p(len_ps); tok[tok_cnt] = t; tok_cnt++;
            end
         end
         M_NUMBER: begin
            if (is_digit(c)) absorbed = 1'b1;
            else if (c == ".") begin
               mode_in = M_NUMDOT; absorbed = 1'b1;
            end else begin
               t.token_kind = K_NUMBER; t.start_offset = sat16p(start_ff);
               t.token_length = sat16p(len_ps); tok[tok_cnt] = t; tok_cnt++;
            end
         end
         M_NUMDOT: begin
            if (is_digit(c)) begin
               mode_in = M_FRACTION; absorbed = 1'b1;
            end else begin
               t.token_kind = K_NUMBER; t.start_offset = sat16p(start_ff);
               t.token_length = sat16p(len_ps1); tok[tok_cnt] = t; tok_cnt++;
               t = '0;
               t.token_kind = K_DOT;
               t.start_offset = sat16p((p != '0) ? p - 1'b1 : '0);
               t.token_length = 16'd1; tok[tok_cnt] = t; tok_cnt++;
            end
         end
         M_FRACTION: begin
            if (is_digit(c)) absorbed = 1'b1;
            else begin
               t.token_kind = K_NUMBER; t.start_offset = sat16p(start_ff);
               t.token_length = sat16p(len_ps); tok[tok_cnt] = t; tok_cnt++;
            end
         end
         M_STRING: begin
            if (c == "\"") begin
               t.token_kind = K_STRING; t.start_offset = sat16p(start_ff);
               t.token_length = sat16p((p >= start_ff) ? p - start_ff + 1'b1 : '0);
               if (p >= start_ff && p - start_ff == PosMax) t.token_length = 16'hFFFF;
               tok[tok_cnt] = t; tok_cnt++;
               mode_in = M_IDLE; absorbed = 1'b1;
            end else if (c == 8'd0) begin
               t.token_kind = K_ERROR; t.start_offset = sat16p(start_ff);
               t.error_kind = E_UNTERMINATED; tok[tok_cnt] = t; tok_cnt++;
            end else begin
               if (c == "\n" && ln != LineMax) ln = ln + 1'b1;
               absorbed = 1'b1;
            end
         end
         default: ;
      endcase
      if (!absorbed) mode_in = M_IDLE;

      // token line numbers for resolved tokens
      for (int i = 0; i < 3; i++) tok[i].line_number = sat16l(ln);

      // start of a new lexeme
      if (!absorbed) begin
         t = '0;
         t.start_offset = sat16p(p);
         t.line_number  = sat16l(ln);
         t.token_length = 16'd1;
         case (c)
            8'd0: begin
               t.token_kind = K_EOF; t.token_length = 16'd0;
               tok[tok_cnt] = t; tok_cnt++;
            end
            " ", 8'h0d, 8'h09: ;
            "\n": if (ln != LineMax) ln = ln + 1'b1;
            "/": begin mode_in = M_SLASH; start_in = p; end
            "(": begin t.token_kind = K_LPAREN; tok[tok_cnt] = t; tok_cnt++; end
            ")": begin t.token_kind = K_RPAREN; tok[tok_cnt] = t; tok_cnt++; end
            "{": begin t.token_kind = K_LBRACE; tok[tok_cnt] = t; tok_cnt++; end
            "}": begin t.token_kind = K_RBRACE; tok[tok_cnt] = t; tok_cnt++; end
            ";": begin t.token_kind = K_SEMI; tok[tok_cnt] = t; tok_cnt++; end
            ",": begin t.token_kind = K_COMMA; tok[tok_cnt] = t; tok_cnt++; end
            ".": begin t.token_kind = K_DOT; tok[tok_cnt] = t; tok_cnt++; end
            "-": begin t.token_kind = K_MINUS; tok[tok_cnt] = t; tok_cnt++; end
            "+": begin t.token_kind = K_PLUS; tok[tok_cnt] = t; tok_cnt++; end
            "*": begin t.token_kind = K_STAR; tok[tok_cnt] = t; tok_cnt++; end
            "!", "=", "<", ">": begin
               mode_in = M_OP; pend_in = c; start_in = p;
            end
            "\"": begin mode_in = M_STRING; start_in = p; end
            default: begin
               if (is_alpha(c)) begin
                  mode_in = M_IDENT; start_in = p; toolong_in = 1'b0;
                  pw_en = 1'b1; pw_idx = 3'd0;
               end else if (is_digit(c)) begin
                  mode_in = M_NUMBER; start_in = p;
               end else begin
                  t.token_kind = K_ERROR; t.token_length = 16'd0;
                  t.error_kind = E_UNEXPECTED; tok[tok_cnt] = t; tok_cnt++;
               end
            end
         endcase
      end

      // end of source restarts position and line
      if (!absorbed && c == 8'd0) begin
         pos_in = '0;
         ln     = LINE_BITS'(1);
      end else if (pos_ff != PosMax) begin
         pos_in = pos_ff + 1'b1;
      end
      line_in = ln;

      if (tok_cnt != 2'd0) tok[tok_cnt - 2'd1].last_of_run = 1'b1;
   end

   // input side accepts whenever the input register is free or being consumed
   assign req.ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
      if (req.ready && req.valid) in_byte_ff <= req.payload.source_byte;
   end

   // scanner state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= M_IDLE;
         pend_ff    <= '0;
         start_ff   <= '0;
         pos_ff     <= '0;
         line_ff    <= LINE_BITS'(1);
         toolong_ff <= 1'b0;
      end else if (fire) begin
         mode_ff    <= mode_in;
         pend_ff    <= pend_in;
         start_ff   <= start_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         toolong_ff <= toolong_in;
      end
   end

   // identifier prefix store
   always_ff @(posedge clock) begin
      if (fire && pw_en) prefix_ff[pw_idx] <= c;
   end

   // token queue
   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff  <= 2'd0;
         q_head_ff <= 2'd0;
      end else if (fire) begin
         q_cnt_ff  <= tok_cnt;
         q_head_ff <= 2'd0;
      end else if (rsp.valid && rsp.ready) begin
         q_cnt_ff  <= q_cnt_ff - 2'd1;
         q_head_ff <= q_head_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         for (int i = 0; i < 3; i++) q_ff[i] <= tok[i];
      end
   end

   assign rsp.valid   = q_cnt_ff != 2'd0;
   assign rsp.payload = q_ff[q_head_ff];

`ifndef SYNTHESIS
   a_no_fire_busy: assert property (@(posedge clock) disable iff (reset)
      fire |-> (q_cnt_ff == 2'd0 || (q_cnt_ff == 2'd1 && rsp.ready)))
      else $error("scan while queue busy");
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> q_head_ff + q_cnt_ff <= 3'd3) else $error("queue overrun");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.payload.last_of_run == (q_cnt_ff == 2'd1))
      else $error("last flag mismatch");
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0) else $error("line count zero");
`endif

endmodule
